@@ hdl/assert_macros.svh @@
// Assertion macros used by the checker file of the 3x3 box filter.
// The macros expect clk_i and rst_ni to be visible where they are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property checked on every rising clock edge outside reset.
`define BF3_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// A signal that must keep its value in the cycle after a condition.
`define BF3_ASSERT_HOLD(lbl, cond, sig, msg) \
  `BF3_ASSERT(lbl, (cond) |=> $stable(sig), msg)

`endif

@@ hdl/bf3_pkg.sv @@
// Package of the 3x3 box filter: word types, register codes and the
// reciprocal table used by the channel lanes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bf3_pkg;

  localparam int PIX_W       = 8;
  localparam int LANES       = 3;
  localparam int TAPS        = 9;
  localparam int SUM_W       = 12;
  localparam int CNT_W       = 4;
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP_W     = 21;
  localparam int PROD_W      = SUM_W + RECIP_W;
  localparam int WIDTH_W     = 11;
  localparam int HEIGHT_W    = 13;
  localparam int ROW_W       = 14;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 13;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic             cmd;
    logic [PIX_W-1:0] in_blue;
    logic [PIX_W-1:0] in_green;
    logic [PIX_W-1:0] in_red;
  } bf3_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] out_blue;
    logic [PIX_W-1:0] out_green;
    logic [PIX_W-1:0] out_red;
    logic             frame_last;
  } bf3_out_t;

  typedef struct packed {
    logic sum_en;
    logic mul_en;
  } bf3_lane_ctl_t;

  // Rounded-up 2^20 / count. Exact floor division for sums below 2304.
  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] count);
    logic [RECIP_W-1:0] r;
    case (count)
      4'd2:    r = 21'd524288;
      4'd3:    r = 21'd349526;
      4'd4:    r = 21'd262144;
      4'd5:    r = 21'd209716;
      4'd6:    r = 21'd174763;
      4'd7:    r = 21'd149797;
      4'd8:    r = 21'd131072;
      4'd9:    r = 21'd116509;
      default: r = 21'd1048576;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hdl/bf3_stream_if.sv @@
// Valid/ready stream interface carrying one word of a packed type.
// Used with the word types of bf3_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface bf3_stream_if #(
  parameter type T = logic
) ();

  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface

`default_nettype wire

@@ hdl/bf3_lane.sv @@
// One channel lane of the box filter: masked 3x3 sum, then the mean by a
// reciprocal multiply. Depends on bf3_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bf3_lane import bf3_pkg::*; (
  input  logic                           clk_i,
  input  bf3_lane_ctl_t                  ctl_i,
  input  logic [TAPS-1:0][PIX_W-1:0]     taps_i,
  input  logic [TAPS-1:0]                mask_i,
  input  logic [CNT_W-1:0]               count_i,
  output logic [PIX_W-1:0]               mean_o
);

  logic [SUM_W-1:0]  sum_d;
  logic [SUM_W-1:0]  sum_q;
  logic [PROD_W-1:0] prod_q;

  always_comb begin
    sum_d = '0;
    for (int t = 0; t < TAPS; t++) begin
      if (mask_i[t]) begin
        sum_d = sum_d + SUM_W'(taps_i[t]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.sum_en) begin
      sum_q <= sum_d;
    end
    if (ctl_i.mul_en) begin
      prod_q <= PROD_W'(sum_q) * PROD_W'(recip(count_i));
    end
  end

  assign mean_o = prod_q[RECIP_SHIFT +: PIX_W];

endmodule

`default_nettype wire

@@ hdl/bf3_merge.sv @@
// Merges the three lane means and the frame mark into the output word and
// holds it in the output register. Depends on bf3_pkg and bf3_stream_if.
`timescale 1ns / 1ps
`default_nettype none

module bf3_merge import bf3_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         load_i,
  input  logic [LANES-1:0][PIX_W-1:0]  mean_i,
  input  logic                         last_i,
  output logic                         free_o,
  bf3_stream_if.source                 out_o
);

  logic     valid_q;
  bf3_out_t data_q;

  assign free_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q.out_blue   <= mean_i[0];
      data_q.out_green  <= mean_i[1];
      data_q.out_red    <= mean_i[2];
      data_q.frame_last <= last_i;
    end
  end

  assign out_o.valid = valid_q;
  assign out_o.data  = data_q;

endmodule

`default_nettype wire

@@ hdl/box_filter_3x3_rgb_top.sv @@
// Top level of the streaming 3x3 RGB box filter: sequencer, row stores,
// window and counters. Depends on bf3_pkg, bf3_stream_if, bf3_lane, bf3_merge.
//
//   Port    Dir  Word       Handshake
//   in_i    in   bf3_in_t   valid/ready
//   out_o   out  bf3_out_t  valid/ready
//   cfg_*   in   index+data write enable, no wait
//
// A word that yields a result goes through the row-store read, the window
// update with the lane sums, the reciprocal multiply, and the load of the
// output register. A pixel word that yields no result returns to idle after
// the window update; a flush word during the frame is dropped in idle.
// Reset is asynchronous; it sets width and height to 1024 and clears the
// counters and window. The row stores are not cleared.
// A finished word waits in the output register while the next word is taken;
// the sequencer only stalls when a new result meets a full output register.
`timescale 1ns / 1ps
`default_nettype none

module box_filter_3x3_rgb_top import bf3_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  bf3_stream_if.sink            in_i,
  bf3_stream_if.source          out_o
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int EW    = (WW > WIDTH_W) ? WW : WIDTH_W;
  localparam int PX_W  = LANES * PIX_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_MUL,
    ST_OUT
  } state_e;

  state_e               state_q;
  logic [WIDTH_W-1:0]   width_q;
  logic [HEIGHT_W-1:0]  height_q;
  logic [ROW_W-1:0]     in_row_q;
  logic [COL_W-1:0]     in_col_q;
  logic [HEIGHT_W-1:0]  out_row_q;
  logic [COL_W-1:0]     out_col_q;
  logic [PX_W-1:0]      win_q [6];
  logic [PX_W-1:0]      pix_q;
  logic [CNT_W-1:0]     count_q;
  logic                 last_q;

  logic [PX_W-1:0]      older_mem [MAX_WIDTH];
  logic [PX_W-1:0]      newer_mem [MAX_WIDTH];
  logic [PX_W-1:0]      older_rd_q;
  logic [PX_W-1:0]      newer_rd_q;

  logic [WW-1:0]        eff_w;
  logic [HEIGHT_W-1:0]  eff_h;
  logic                 done;
  logic                 in_acc;
  logic                 start;
  logic                 calc;
  logic                 produce;
  logic                 last_d;
  logic                 cfg_hit;
  logic                 restart;
  logic                 in_wrap;
  logic                 out_wrap;
  logic                 out_free;
  logic [2:0]           rv;
  logic [2:0]           cv;
  logic [TAPS-1:0]      mask;
  logic [CNT_W-1:0]     count_d;
  logic [PX_W-1:0]      tap_px [TAPS];
  logic [LANES-1:0][TAPS-1:0][PIX_W-1:0] lane_taps;
  logic [LANES-1:0][PIX_W-1:0]           lane_mean;
  bf3_lane_ctl_t        lane_ctl;

  always_comb begin
    if (width_q == '0) begin
      eff_w = WW'(1);
    end else if (EW'(width_q) > EW'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(width_q);
    end
  end

  assign eff_h   = (height_q == '0) ? HEIGHT_W'(1) : height_q;
  assign done    = in_row_q >= ROW_W'(eff_h);
  assign in_acc  = in_i.valid && in_i.ready;
  assign start   = in_acc && !(in_i.data.cmd == CMD_FLUSH && !done);
  assign calc    = (state_q == ST_CALC);
  assign produce = (in_row_q >= ROW_W'(2)) || (in_row_q == ROW_W'(1) && in_col_q != '0);

  assign in_i.ready = (state_q == ST_IDLE);

  assign rv[0] = (out_row_q != '0);
  assign rv[1] = 1'b1;
  assign rv[2] = (ROW_W'(out_row_q) + ROW_W'(1)) < ROW_W'(eff_h);
  assign cv[0] = (out_col_q != '0);
  assign cv[1] = 1'b1;
  assign cv[2] = (WW'(out_col_q) + WW'(1)) < eff_w;
  assign last_d = !rv[2] && !cv[2];

  assign in_wrap  = (WW'(in_col_q) + WW'(1)) >= eff_w;
  assign out_wrap = !cv[2];

  assign cfg_hit = cfg_we_i && (cfg_idx_i == REG_IMAGE_WIDTH || cfg_idx_i == REG_IMAGE_HEIGHT);
  assign restart = cfg_hit || (calc && produce && last_d);

  always_comb begin
    count_d = '0;
    for (int t = 0; t < TAPS; t++) begin
      mask[t] = rv[t % 3] && cv[t / 3];
      count_d = count_d + CNT_W'(mask[t]);
      if (t < 6) begin
        tap_px[t] = win_q[t];
      end else if (t == 6) begin
        tap_px[t] = older_rd_q;
      end else if (t == 7) begin
        tap_px[t] = newer_rd_q;
      end else begin
        tap_px[t] = pix_q;
      end
    end
    for (int k = 0; k < LANES; k++) begin
      for (int t = 0; t < TAPS; t++) begin
        lane_taps[k][t] = tap_px[t][k*PIX_W +: PIX_W];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      older_rd_q <= older_mem[in_col_q];
      newer_rd_q <= newer_mem[in_col_q];
    end
    if (calc) begin
      older_mem[in_col_q] <= newer_rd_q;
      newer_mem[in_col_q] <= pix_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      width_q   <= WIDTH_W'(1024);
      height_q  <= HEIGHT_W'(1024);
      in_row_q  <= '0;
      in_col_q  <= '0;
      out_row_q <= '0;
      out_col_q <= '0;
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
      pix_q     <= '0;
      count_q   <= CNT_W'(1);
      last_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_idx_i))
          REG_IMAGE_WIDTH:  width_q  <= cfg_data_i[WIDTH_W-1:0];
          REG_IMAGE_HEIGHT: height_q <= cfg_data_i[HEIGHT_W-1:0];
          default: ;
        endcase
      end

      if (restart) begin
        in_row_q  <= '0;
        in_col_q  <= '0;
        out_row_q <= '0;
        out_col_q <= '0;
        for (int i = 0; i < 6; i++) begin
          win_q[i] <= '0;
        end
      end else if (calc) begin
        if (produce) begin
          if (out_wrap) begin
            out_col_q <= '0;
            out_row_q <= out_row_q + HEIGHT_W'(1);
          end else begin
            out_col_q <= out_col_q + COL_W'(1);
          end
        end
        win_q[0] <= win_q[3];
        win_q[1] <= win_q[4];
        win_q[2] <= win_q[5];
        win_q[3] <= older_rd_q;
        win_q[4] <= newer_rd_q;
        win_q[5] <= pix_q;
        if (in_wrap) begin
          in_col_q <= '0;
          in_row_q <= in_row_q + ROW_W'(1);
        end else begin
          in_col_q <= in_col_q + COL_W'(1);
        end
      end

      unique case (state_q)
        ST_IDLE: begin
          if (start) begin
            pix_q   <= done ? '0 : {in_i.data.in_red, in_i.data.in_green, in_i.data.in_blue};
            state_q <= ST_CALC;
          end
        end
        ST_CALC: begin
          count_q <= count_d;
          last_q  <= last_d;
          state_q <= produce ? ST_MUL : ST_IDLE;
        end
        ST_MUL: begin
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign lane_ctl.sum_en = calc;
  assign lane_ctl.mul_en = (state_q == ST_MUL);

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    bf3_lane u_lane (
      .clk_i   (clk_i),
      .ctl_i   (lane_ctl),
      .taps_i  (lane_taps[k]),
      .mask_i  (mask),
      .count_i (count_q),
      .mean_o  (lane_mean[k])
    );
  end

  bf3_merge u_merge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i ((state_q == ST_OUT) && out_free),
    .mean_i (lane_mean),
    .last_i (last_q),
    .free_o (out_free),
    .out_o  (out_o)
  );

endmodule

`default_nettype wire

@@ hdl/bf3_checker.sv @@
// Port-level checker of the 3x3 box filter and its bind to the top level.
// Depends on bf3_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bf3_checker import bf3_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_i,
  input logic     in_cmd_i,
  input logic     out_valid_i,
  input logic     out_ready_i,
  input bf3_out_t out_data_i
);

  `BF3_ASSERT(a_out_valid_hold, out_valid_i && !out_ready_i |=> out_valid_i, "output word dropped while stalled")
  `BF3_ASSERT_HOLD(a_out_data_hold, out_valid_i && !out_ready_i, out_data_i, "output word changed while stalled")
  `BF3_ASSERT(a_pixel_busy, in_valid_i && in_ready_i && in_cmd_i == CMD_PIXEL |=> !in_ready_i, "pixel word too early")
  `BF3_ASSERT(a_ready_fall, $fell(in_ready_i) |-> $past(in_valid_i && in_ready_i), "input ready fell without a word")

endmodule

bind box_filter_3x3_rgb_top bf3_checker u_bf3_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_cmd_i    (in_i.data.cmd),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for the streaming 3x3 RGB box filter: frames of random pixels
// under bursty input and stalling output, checked against an in-bench window-mean predictor.
// Depends on bf3_pkg, bf3_stream_if and box_filter_3x3_rgb_top.
`timescale 1ns / 1ps

module tb_top;
  import bf3_pkg::*;

  localparam int unsigned MAXW = 1024;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_HALF,
    RX_SPARSE,
    RX_PULSE
  } rx_mode_e;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  bf3_stream_if #(.T(bf3_in_t))  in_if ();
  bf3_stream_if #(.T(bf3_out_t)) out_if ();

  box_filter_3x3_rgb_top #(
    .MAX_WIDTH(MAXW)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .in_i      (in_if),
    .out_o     (out_if)
  );

  logic [23:0]          row_old [MAXW];
  logic [23:0]          row_new [MAXW];
  logic [23:0]          win_col [6];
  int unsigned          pix_row, pix_col, avg_row, avg_col;
  logic [WIDTH_W-1:0]   cfg_width;
  logic [HEIGHT_W-1:0]  cfg_height;

  bf3_in_t     word_q [$];
  bf3_out_t    mean_q [$];
  bf3_out_t    want;
  int unsigned mism_cnt;
  int unsigned burst_left, gap_left;
  int unsigned rx_left, rx_tick;
  rx_mode_e    rx_mode;
  logic        rx_go;
  logic        rx_hold;
  bit          hold_go;

  function automatic int unsigned eff_width(logic [WIDTH_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAXW) return MAXW;
    return v;
  endfunction

  function automatic int unsigned eff_height(logic [HEIGHT_W-1:0] v);
    return (v == 0) ? 1 : v;
  endfunction

  function automatic void frame_restart();
    for (int i = 0; i < 6; i++) win_col[i] = '0;
    pix_row = 0;
    pix_col = 0;
    avg_row = 0;
    avg_col = 0;
  endfunction

  function automatic void box_cfg_apply(logic [CFG_IDX_W-1:0] idx,
                                        logic [CFG_DATA_W-1:0] data);
    if (idx == REG_IMAGE_WIDTH) begin
      cfg_width = data[WIDTH_W-1:0];
      frame_restart();
    end else if (idx == REG_IMAGE_HEIGHT) begin
      cfg_height = data[HEIGHT_W-1:0];
      frame_restart();
    end
  endfunction

  function automatic void box_mean_predict(bf3_in_t word);
    int unsigned w, h, ic, qr, qc, count;
    int unsigned sum [3];
    logic [23:0] px;
    logic [23:0] tap;
    logic [23:0] fresh [3];
    bit          rv [3];
    bit          cv [3];
    bf3_out_t    res;
    w = eff_width(cfg_width);
    h = eff_height(cfg_height);
    if (word.cmd == CMD_FLUSH && pix_row < h) return;
    px = (pix_row < h) ? {word.in_red, word.in_green, word.in_blue} : 24'h0;
    ic = (pix_col < w) ? pix_col : 0;
    fresh[0] = row_old[ic];
    fresh[1] = row_new[ic];
    fresh[2] = px;
    if (pix_row >= 2 || (pix_row == 1 && pix_col >= 1)) begin
      qr = avg_row;
      qc = avg_col;
      rv[0] = (qr >= 1);
      rv[1] = 1'b1;
      rv[2] = (qr + 1 < h);
      cv[0] = (qc >= 1);
      cv[1] = 1'b1;
      cv[2] = (qc + 1 < w);
      count = 0;
      sum = '{0, 0, 0};
      for (int c = 0; c < 3; c++) begin
        for (int r = 0; r < 3; r++) begin
          if (rv[r] && cv[c]) begin
            tap = (c == 0) ? win_col[r] : ((c == 1) ? win_col[3 + r] : fresh[r]);
            for (int k = 0; k < 3; k++) sum[k] += tap[8 * k +: 8];
            count++;
          end
        end
      end
      if (count == 0) count = 1;
      res.out_blue   = 8'(sum[0] / count);
      res.out_green  = 8'(sum[1] / count);
      res.out_red    = 8'(sum[2] / count);
      res.frame_last = (qr + 1 >= h) && (qc + 1 >= w);
      mean_q.push_back(res);
      if (res.frame_last) begin
        row_old[ic] = row_new[ic];
        row_new[ic] = px;
        frame_restart();
        return;
      end
      avg_col = qc + 1;
      if (avg_col >= w) begin
        avg_col = 0;
        avg_row = qr + 1;
      end
    end
    for (int i = 0; i < 3; i++) begin
      win_col[i]     = win_col[3 + i];
      win_col[3 + i] = fresh[i];
    end
    row_old[ic] = row_new[ic];
    row_new[ic] = px;
    pix_col = ic + 1;
    if (pix_col >= w) begin
      pix_col = 0;
      pix_row++;
    end
  endfunction

  function automatic bf3_in_t pix_word(logic [7:0] b, logic [7:0] g, logic [7:0] r);
    bf3_in_t wd;
    wd.cmd      = CMD_PIXEL;
    wd.in_blue  = b;
    wd.in_green = g;
    wd.in_red   = r;
    return wd;
  endfunction

  function automatic bf3_in_t rand_word(logic cmd);
    bf3_in_t wd;
    wd.cmd      = cmd;
    wd.in_blue  = 8'($urandom);
    wd.in_green = 8'($urandom);
    wd.in_red   = 8'($urandom);
    if ($urandom_range(0, 7) == 0) begin
      wd.in_blue  = 8'hFF;
      wd.in_green = 8'hFF;
      wd.in_red   = 8'hFF;
    end
    return wd;
  endfunction

  task automatic push_pixels(int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 15) == 0) word_q.push_back(rand_word(CMD_FLUSH));
      word_q.push_back(rand_word(CMD_PIXEL));
    end
  endtask

  task automatic push_tail(int unsigned w);
    for (int unsigned i = 0; i <= w; i++) word_q.push_back(rand_word(1'($urandom_range(0, 1))));
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 3)) word_q.push_back(rand_word(CMD_FLUSH));
    end
  endtask

  task automatic settle();
    @(negedge clk_i);
    while (word_q.size() != 0 || in_if.valid || mean_q.size() != 0) @(negedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    box_cfg_apply(idx, data);
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("tb_top: errors");
    $finish;
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_if.ready) begin
      if (gap_left != 0) begin
        gap_left    <= gap_left - 1;
        in_if.valid <= 1'b0;
      end else if (word_q.size() != 0) begin
        in_if.valid <= 1'b1;
        in_if.data  <= word_q.pop_front();
        if (burst_left > 1) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready) box_mean_predict(in_if.data);
  end

  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(0, 3));
      rx_left <= $urandom_range(16, 160);
    end else begin
      rx_left <= rx_left - 1;
    end
    rx_tick <= rx_tick + 1;
    case (rx_mode)
      RX_OPEN:   rx_go = 1'b1;
      RX_HALF:   rx_go = 1'($urandom_range(0, 1));
      RX_SPARSE: rx_go = ($urandom_range(0, 4) == 0);
      default:   rx_go = (rx_tick % 3 == 0);
    endcase
    out_if.ready <= rx_go && !rx_hold;
  end

  initial begin
    wait (hold_go);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (400) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (mean_q.size() == 0) begin
        if (mism_cnt < 10) begin
          $display("unexpected word: b=%0d g=%0d r=%0d last=%0b", out_if.data.out_blue,
                   out_if.data.out_green, out_if.data.out_red, out_if.data.frame_last);
        end
        mism_cnt++;
      end else begin
        want = mean_q.pop_front();
        if (out_if.data.out_blue !== want.out_blue || out_if.data.out_green !== want.out_green ||
            out_if.data.out_red !== want.out_red ||
            out_if.data.frame_last !== want.frame_last) begin
          if (mism_cnt < 10) begin
            $display("mismatch: got b=%0d g=%0d r=%0d last=%0b, want b=%0d g=%0d r=%0d last=%0b",
                     out_if.data.out_blue, out_if.data.out_green, out_if.data.out_red,
                     out_if.data.frame_last, want.out_blue, want.out_green, want.out_red,
                     want.frame_last);
          end
          mism_cnt++;
        end
      end
    end
  end

  initial begin
    int unsigned     w_eff, h_eff, n, cut, rand_pix;
    bit              need_cfg;
    logic [10:0]     w_val;
    logic [12:0]     h_val;
    rst_ni       = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = REG_IMAGE_WIDTH;
    cfg_data     = '0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
    rx_hold      = 1'b0;
    rx_mode      = RX_OPEN;
    rx_left      = 0;
    rx_tick      = 0;
    burst_left   = 0;
    gap_left     = 0;
    mism_cnt     = 0;
    hold_go      = 1'b0;
    rand_pix     = 0;
    need_cfg     = 1'b0;
    for (int i = 0; i < MAXW; i++) begin
      row_old[i] = '0;
      row_new[i] = '0;
    end
    cfg_width  = 11'd1024;
    cfg_height = 13'd1024;
    frame_restart();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    cfg_write(REG_IMAGE_WIDTH, 13'd0);
    cfg_write(REG_IMAGE_HEIGHT, 13'd0);
    word_q.push_back(pix_word(8'hFF, 8'hFF, 8'hFF));
    word_q.push_back(rand_word(CMD_FLUSH));
    word_q.push_back(pix_word(8'h00, 8'h80, 8'h7F));
    settle();

    cfg_write(REG_IMAGE_WIDTH, 13'd1);
    cfg_write(REG_IMAGE_HEIGHT, 13'd3);
    word_q.push_back(pix_word(8'hFF, 8'h00, 8'hFF));
    word_q.push_back(pix_word(8'h00, 8'hFF, 8'hFF));
    word_q.push_back(pix_word(8'hFF, 8'hFF, 8'h00));
    word_q.push_back(rand_word(CMD_FLUSH));
    word_q.push_back(rand_word(CMD_FLUSH));
    settle();

    cfg_write(REG_IMAGE_HEIGHT, 13'd1);
    cfg_write(REG_IMAGE_WIDTH, 13'd3);
    word_q.push_back(pix_word(8'h00, 8'h00, 8'h00));
    word_q.push_back(pix_word(8'hFF, 8'hFF, 8'hFF));
    word_q.push_back(pix_word(8'hFF, 8'h01, 8'h80));
    word_q.push_back(rand_word(CMD_FLUSH));
    word_q.push_back(pix_word(8'hFF, 8'hFF, 8'hFF));
    word_q.push_back(rand_word(CMD_FLUSH));
    word_q.push_back(pix_word(8'h55, 8'hAA, 8'h01));
    settle();

    cfg_write(REG_IMAGE_WIDTH, 13'h1803);
    cfg_write(REG_IMAGE_HEIGHT, 13'd3);
    for (int i = 0; i < 9; i++) begin
      word_q.push_back(pix_word((i % 2 != 0) ? 8'hFF : 8'h00, (i % 3 == 0) ? 8'hFF : 8'h00,
                                8'(i * 31)));
      if (i == 4) word_q.push_back(rand_word(CMD_FLUSH));
    end
    repeat (4) word_q.push_back(rand_word(CMD_FLUSH));
    settle();

    cfg_write(REG_IMAGE_WIDTH, 13'd4);
    cfg_write(REG_IMAGE_HEIGHT, 13'd4);
    push_pixels(9);
    hold_go = 1'b1;
    settle();
    cfg_write(REG_SPARE, 13'($urandom));
    push_pixels(7);
    push_tail(4);
    push_pixels(6);
    need_cfg = 1'b1;

    while (rand_pix < 240) begin
      if (need_cfg || $urandom_range(0, 3) != 0) begin
        settle();
        w_val = ($urandom_range(0, 3) == 0) ? 11'($urandom_range(9, 24)) :
                11'($urandom_range(1, 8));
        if ($urandom_range(0, 15) == 0) w_val = '0;
        h_val = (w_val > 8) ? 13'($urandom_range(1, 3)) :
                (($urandom_range(0, 3) == 0) ? 13'($urandom_range(7, 12)) :
                 13'($urandom_range(1, 6)));
        if ($urandom_range(0, 15) == 0) h_val = '0;
        if (need_cfg || $urandom_range(0, 1) != 0) begin
          cfg_write(REG_IMAGE_WIDTH, {2'($urandom_range(0, 3)), w_val});
        end
        cfg_write(REG_IMAGE_HEIGHT, h_val);
        need_cfg = 1'b0;
      end
      w_eff = eff_width(cfg_width);
      h_eff = eff_height(cfg_height);
      n = w_eff * h_eff;
      if ($urandom_range(0, 9) == 0) begin
        cut = $urandom_range(1, n);
        push_pixels(cut);
        settle();
        if ($urandom_range(0, 1) != 0) begin
          cfg_write(REG_SPARE, 13'($urandom));
          push_pixels(n - cut);
          push_tail(w_eff);
        end else begin
          need_cfg = 1'b1;
        end
      end else begin
        push_pixels(n);
        push_tail(w_eff);
      end
      rand_pix += n;
    end

    settle();
    repeat (20) @(posedge clk_i);
    if (mism_cnt == 0 && mean_q.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
